>>> rtl/wmcf_pkg.sv
// ----------------------------------------------------------------------------
// wmcf_pkg
// Shared types and constants of the windowed median current filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wmcf_pkg;

   // Default window length (odd) and result queue depth
   localparam int WINDOW_SIZE_DEF = 5;
   localparam int RSP_DEPTH_DEF   = 4;

   // Field widths
   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int OFFSET_W    = 16;
   localparam int CURRENT_W   = 22;
   localparam int PRODUCT_W   = SAMPLE_W + GAIN_W;
   localparam int Q_SHIFT     = 12;
   localparam int SCALED_W    = PRODUCT_W - Q_SHIFT;

   // Stream and register port widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_GAIN   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_OFFSET = 4'd1;

   // Register reset values: unity gain in Q4.12, no offset
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'h1000;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'h0000;

   // Median stage output
   typedef struct packed {
      logic                valid;
      logic [SAMPLE_W-1:0] median;
   } med_stage_type;

   // Scaling registers
   typedef struct packed {
      logic [GAIN_W-1:0]   gain;
      logic [OFFSET_W-1:0] offset;
   } csr_regs_type;

   // Result item, median in the low bits
   typedef struct packed {
      logic [CURRENT_W-1:0] current_ma;
      logic [SAMPLE_W-1:0]  median_sample;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> rtl/windowed_median_current_filter.sv
// ----------------------------------------------------------------------------
// windowed_median_current_filter
// Sliding-window median of shunt ADC samples, scaled to a current in mA.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload (low bit first)          | transfer when
//  --------+-----------+----------------------------------+-----------------------
//  req     | in        | adc_sample[15:0]                 | req_tvalid & req_tready
//  rsp     | out       | median_sample[15:0],             | rsp_tvalid & rsp_tready
//          |           | current_ma[37:16], zeros[39:38]  |
//  csr     | in        | csr_index 0 gain, 1 offset       | csr_valid & csr_ready
//
//  One sample per cycle while req_tready is high; a result is offered once
//  its transfer passes window write, rank-and-select network, multiply into queue.
//  Reset clears the window to zeros, sets gain to 1.0 (Q4.12) and offset to 0.
//  Up to RSP_DEPTH items may be outstanding; beyond that req_tready drops
//  until the result side takes a transfer. req_tready never depends on
//  rsp_tready in the same cycle.
//
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_median_current_filter #(
   parameter int WINDOW_SIZE = wmcf_pkg::WINDOW_SIZE_DEF,
   parameter int RSP_DEPTH   = wmcf_pkg::RSP_DEPTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // req_tdata: adc_sample[15:0]
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [wmcf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // rsp_tdata: median_sample[15:0], current_ma[37:16], zero pad [39:38]
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [wmcf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [wmcf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire [wmcf_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int OCC_W = $clog2(RSP_DEPTH + 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(RSP_DEPTH);
   localparam int PAD_W = wmcf_pkg::RSP_TDATA_W - $bits(wmcf_pkg::rsp_item_type);

   wmcf_pkg::csr_regs_type  regs_ff;
   wmcf_pkg::csr_regs_type  regs_in;
   logic [OCC_W-1:0]        occ_ff;
   logic [OCC_W-1:0]        occ_in;
   logic                    req_xfer;
   logic                    rsp_xfer;
   wmcf_pkg::med_stage_type med_stage;
   logic                    item_valid;
   wmcf_pkg::rsp_item_type  item;
   wmcf_pkg::rsp_item_type  rsp_item;

   // Register writes: take every transfer, drop indexes beyond the list
   assign csr_ready = !reset;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wmcf_pkg::CSR_CURRENT_GAIN:   regs_in.gain   = csr_data;
            wmcf_pkg::CSR_CURRENT_OFFSET: regs_in.offset = csr_data;
            default:                      regs_in        = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.gain   <= wmcf_pkg::GAIN_RESET;
         regs_ff.offset <= wmcf_pkg::OFFSET_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   // Count items in flight or queued; the queue can never overflow as long as
   // this count stays within its depth, so the pipeline itself never stalls
   assign req_tready = !reset && (occ_ff != OCC_FULL);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   always_comb begin
      case ({req_xfer, rsp_xfer})
         2'b10:   occ_in = occ_ff + 1'b1;
         2'b01:   occ_in = occ_ff - 1'b1;
         default: occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // Window write and median select
   wmcf_median_window #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .push    (req_xfer),
      .sample  (req_tdata[wmcf_pkg::SAMPLE_W-1:0]),
      .med_out (med_stage)
   );

   // Gain and offset; the product is registered by the queue
   wmcf_scale u_scale (
      .med_in     (med_stage),
      .regs       (regs_ff),
      .item_valid (item_valid),
      .item       (item)
   );

   // Hold finished results until the result side takes them
   wmcf_rsp_fifo #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (item_valid),
      .wr_item  (item),
      .rd_en    (rsp_xfer),
      .rd_valid (rsp_tvalid),
      .rd_item  (rsp_item)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_item};

endmodule

`default_nettype wire

>>> rtl/wmcf_median_window.sv
// ----------------------------------------------------------------------------
// wmcf_median_window
// Ring window of samples and a parallel rank network that registers the median.
// ----------------------------------------------------------------------------
`default_nettype none

module wmcf_median_window #(
   parameter int WINDOW_SIZE = wmcf_pkg::WINDOW_SIZE_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           push,
   input  wire [wmcf_pkg::SAMPLE_W-1:0]  sample,
   output wmcf_pkg::med_stage_type       med_out
);

   localparam int POS_W = $clog2(WINDOW_SIZE);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_SIZE - 1);
   localparam logic [POS_W-1:0] RANK_MID = POS_W'(WINDOW_SIZE / 2);

   logic [wmcf_pkg::SAMPLE_W-1:0] window_ff [WINDOW_SIZE];
   logic [wmcf_pkg::SAMPLE_W-1:0] window_in [WINDOW_SIZE];
   logic [POS_W-1:0]              pos_ff;
   logic [POS_W-1:0]              pos_in;
   logic                          fresh_ff;
   logic                          fresh_in;
   logic                          med_vld_ff;
   logic                          med_vld_in;
   logic [wmcf_pkg::SAMPLE_W-1:0] med_ff;
   logic [wmcf_pkg::SAMPLE_W-1:0] med_in;
   logic [POS_W-1:0]              rank [WINDOW_SIZE];
   logic [WINDOW_SIZE-1:0]        is_mid;

   // Overwrite the oldest entry and advance the ring position
   always_comb begin
      window_in = window_ff;
      pos_in    = pos_ff;
      if (push) begin
         window_in[pos_ff] = sample;
         pos_in            = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
      end
   end

   assign fresh_in   = push;
   assign med_vld_in = fresh_ff;

   // Rank each entry; ties break on position so exactly one entry has each rank
   always_comb begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW_SIZE; j++) begin
            if (j != i) begin
               if ((window_ff[j] < window_ff[i]) ||
                   ((window_ff[j] == window_ff[i]) && (j < i))) begin
                  rank[i] = rank[i] + 1'b1;
               end
            end
         end
         is_mid[i] = (rank[i] == RANK_MID);
      end
   end

   always_comb begin
      med_in = '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         if (is_mid[i]) begin
            med_in = med_in | window_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '{default: '0};
         pos_ff     <= '0;
         fresh_ff   <= 1'b0;
         med_vld_ff <= 1'b0;
      end else begin
         window_ff  <= window_in;
         pos_ff     <= pos_in;
         fresh_ff   <= fresh_in;
         med_vld_ff <= med_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      med_ff <= med_in;
   end

   assign med_out.valid  = med_vld_ff;
   assign med_out.median = med_ff;

endmodule

`default_nettype wire

>>> rtl/wmcf_scale.sv
// ----------------------------------------------------------------------------
// wmcf_scale
// Convert the median to milliamps: Q4.12 gain, truncate, add signed offset.
// ----------------------------------------------------------------------------
`default_nettype none

module wmcf_scale (
   input  wmcf_pkg::med_stage_type  med_in,
   input  wmcf_pkg::csr_regs_type   regs,
   output logic                     item_valid,
   output wmcf_pkg::rsp_item_type   item
);

   logic [wmcf_pkg::PRODUCT_W-1:0] product;
   logic [wmcf_pkg::SCALED_W-1:0]  scaled;

   assign product = {{wmcf_pkg::GAIN_W{1'b0}}, med_in.median} *
                    {{wmcf_pkg::SAMPLE_W{1'b0}}, regs.gain};
   assign scaled  = product[wmcf_pkg::PRODUCT_W-1:wmcf_pkg::Q_SHIFT];

   assign item_valid         = med_in.valid;
   assign item.median_sample = med_in.median;
   assign item.current_ma    =
      {{(wmcf_pkg::CURRENT_W - wmcf_pkg::SCALED_W){1'b0}}, scaled} +
      {{(wmcf_pkg::CURRENT_W - wmcf_pkg::OFFSET_W){regs.offset[wmcf_pkg::OFFSET_W-1]}},
       regs.offset};

endmodule

`default_nettype wire

>>> rtl/wmcf_rsp_fifo.sv
// ----------------------------------------------------------------------------
// wmcf_rsp_fifo
// Small result queue that decouples the pipeline from the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wmcf_rsp_fifo #(
   parameter int RSP_DEPTH = wmcf_pkg::RSP_DEPTH_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     wr_en,
   input  wmcf_pkg::rsp_item_type  wr_item,
   input  wire                     rd_en,
   output logic                    rd_valid,
   output wmcf_pkg::rsp_item_type  rd_item
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RSP_DEPTH - 1);

   wmcf_pkg::rsp_item_type mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   assign wr_ptr_in = !wr_en ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !rd_en ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_valid = (count_ff != '0);
   assign rd_item  = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

>>> rtl/wmcf_checker.sv
// ----------------------------------------------------------------------------
// wmcf_checker
// Port-level checks of the windowed median current filter.
// ----------------------------------------------------------------------------
`default_nettype none

module wmcf_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [wmcf_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   // Reset empties the result queue
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // An empty queue only fills from a transfer through window, median and queue
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))
      else $error("result appeared without a matching input transfer");

   // Back-pressure on the input only while results are waiting
   a_full_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

endmodule

bind windowed_median_current_filter wmcf_checker u_wmcf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
